/* src/dod_pkg.sv */
// shared types and constants for the delay overuse detector
// no dependencies; imported by the interfaces and every module
`default_nettype none

package dod_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = 24;

  localparam int MS_W    = 28;
  localparam int GAIN_W  = 24;
  localparam int CAP_W   = 10;
  localparam int CNT_W   = 16;
  localparam int NOW_W   = 40;
  localparam int ACC_W   = 32;
  localparam int STEP_W  = 16;
  localparam int IDX_W   = 8;
  localparam int MAG_W   = 38;
  localparam int PROD_W  = MS_W + GAIN_W;
  localparam int HI_W    = MS_W + STEP_W;
  localparam int DELTA_W = HI_W + 1;
  localparam int NT_W    = DELTA_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_UP_RST    = GAIN_W'(313734);
  localparam logic [GAIN_W-1:0] GAIN_DOWN_RST  = GAIN_W'(654311);
  localparam logic [MS_W-1:0]   OVER_LIMIT_RST = MS_W'((64'(25) << FRAC_BITS) >> 1);
  localparam logic [CAP_W-1:0]  COUNT_CAP_RST  = CAP_W'(60);
  localparam logic [MS_W-1:0]   MARGIN_RST     = MS_W'(64'(15) << FRAC_BITS);
  localparam logic [STEP_W-1:0] MAX_STEP_RST   = STEP_W'(100);
  localparam logic [MS_W-1:0]   FLOOR_RST      = MS_W'(64'(6) << FRAC_BITS);
  localparam logic [MS_W-1:0]   CEILING_RST    = MS_W'(64'(600) << FRAC_BITS);
  localparam logic [MS_W-1:0]   THRESHOLD_RST  = MS_W'((64'(25) << FRAC_BITS) >> 1);

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_UP     = 8'd0,
    REG_GAIN_DOWN   = 8'd1,
    REG_OVER_LIMIT  = 8'd2,
    REG_COUNT_CAP   = 8'd3,
    REG_MARGIN      = 8'd4,
    REG_MAX_STEP    = 8'd5,
    REG_FLOOR       = 8'd6,
    REG_CEILING     = 8'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    USAGE_NORMAL = 2'd0,
    USAGE_UNDER  = 2'd1,
    USAGE_OVER   = 2'd2
  } usage_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_up;
    logic [GAIN_W-1:0] gain_down;
    logic [MS_W-1:0]   over_limit;
    logic [CAP_W-1:0]  count_cap;
    logic [MS_W-1:0]   margin;
    logic [STEP_W-1:0] max_step;
    logic [MS_W-1:0]   floor_thr;
    logic [MS_W-1:0]   ceiling_thr;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_CLASS,
    OP_GAIN,
    OP_STEPH,
    OP_STEPL,
    OP_SUM,
    OP_APPLY,
    OP_CLAMP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic few;
    logic skip;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/dod_ifs.sv */
// handshake channels of the delay overuse detector: estimates, results, register writes
// depends on dod_pkg for field widths
`default_nettype none

interface dod_est_if import dod_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MS_W-1:0]  delay_offset;
  logic [MS_W-1:0]         group_gap;
  logic [CNT_W-1:0]        delta_count;
  logic [NOW_W-1:0]        now_ms;

  modport source (output valid, delay_offset, group_gap, delta_count, now_ms, input ready);
  modport sink (input valid, delay_offset, group_gap, delta_count, now_ms, output ready);
endinterface

interface dod_res_if import dod_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      usage_state;
  logic [MS_W-1:0] current_threshold;

  modport source (output valid, usage_state, current_threshold, input ready);
  modport sink (input valid, usage_state, current_threshold, output ready);
endinterface

interface dod_cfg_if import dod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [MS_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/dod_cfg.sv */
// configuration register file of the delay overuse detector
// depends on dod_pkg for register indexes, widths and reset values
`default_nettype none

module dod_cfg import dod_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [MS_W-1:0]  wr_data,
  output cfg_regs_t             regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_up     <= GAIN_UP_RST;
      regs.gain_down   <= GAIN_DOWN_RST;
      regs.over_limit  <= OVER_LIMIT_RST;
      regs.count_cap   <= COUNT_CAP_RST;
      regs.margin      <= MARGIN_RST;
      regs.max_step    <= MAX_STEP_RST;
      regs.floor_thr   <= FLOOR_RST;
      regs.ceiling_thr <= CEILING_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_GAIN_UP:    regs.gain_up     <= wr_data[GAIN_W-1:0];
        REG_GAIN_DOWN:  regs.gain_down   <= wr_data[GAIN_W-1:0];
        REG_OVER_LIMIT: regs.over_limit  <= wr_data;
        REG_COUNT_CAP:  regs.count_cap   <= wr_data[CAP_W-1:0];
        REG_MARGIN:     regs.margin      <= wr_data;
        REG_MAX_STEP:   regs.max_step    <= wr_data[STEP_W-1:0];
        REG_FLOOR:      regs.floor_thr   <= wr_data;
        REG_CEILING:    regs.ceiling_thr <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/dod_ctrl.sv */
// sequencer of the delay overuse detector: steps the datapath through one item
// depends on dod_pkg for command and status types
`default_nettype none

module dod_ctrl import dod_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SCALE  = 10'b00_0000_0010,
    S_CLASS  = 10'b00_0000_0100,
    S_GAIN   = 10'b00_0000_1000,
    S_STEPH  = 10'b00_0001_0000,
    S_STEPL  = 10'b00_0010_0000,
    S_SUM    = 10'b00_0100_0000,
    S_APPLY  = 10'b00_1000_0000,
    S_CLAMP  = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        if (status.few) begin
          state_next = S_FINISH;
        end else begin
          cmd.op     = OP_SCALE;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.op     = OP_CLASS;
        state_next = status.skip ? S_FINISH : S_GAIN;
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_STEPH;
      end
      S_STEPH: begin
        cmd.op     = OP_STEPH;
        state_next = S_STEPL;
      end
      S_STEPL: begin
        cmd.op     = OP_STEPL;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.op     = OP_APPLY;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/dod_dp.sv */
// datapath of the delay overuse detector: detector state, shared multiplier,
// threshold adaptation and output register; depends on dod_pkg
`default_nettype none

module dod_dp import dod_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  input  wire cfg_regs_t              regs,
  input  wire logic signed [MS_W-1:0] delay_offset,
  input  wire logic [MS_W-1:0]        group_gap,
  input  wire logic [CNT_W-1:0]       delta_count,
  input  wire logic [NOW_W-1:0]       now_ms,
  output logic [1:0]                  usage_state,
  output logic [MS_W-1:0]             current_threshold
);

  // captured item
  logic signed [MS_W-1:0] off_r;
  logic [MS_W-1:0]        gap_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [NOW_W-1:0]       now_r;

  // detector state
  logic [MS_W-1:0]        threshold;
  logic [ACC_W-1:0]       over_accum;
  logic                   over_valid;
  logic [CNT_W-1:0]       over_count;
  logic signed [MS_W-1:0] prev_offset;
  logic [NOW_W-1:0]       last_ms;
  logic                   last_valid;
  usage_t                 mode;

  // working registers
  logic [PROD_W-1:0]      prod;
  logic [MS_W-1:0]        diff_r;
  logic [GAIN_W-1:0]      k_r;
  logic [STEP_W-1:0]      dt_r;
  logic                   rise_r;
  logic [HI_W-1:0]        hi_r;
  logic [STEP_W-1:0]      lo_r;
  logic [DELTA_W-1:0]     step_r;
  logic signed [NT_W-1:0] nt_r;

  // shared multiplier
  logic [MS_W-1:0]        mul_a;
  logic [GAIN_W-1:0]      mul_b;
  logic [PROD_W-1:0]      mul_p;

  logic [CAP_W-1:0]       n_eff;
  logic [MS_W-1:0]        abs_off;

  logic [MAG_W-1:0]       mag;
  logic                   t_neg;
  logic                   above;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_upd;
  logic [CNT_W-1:0]       cnt_upd;
  logic                   fire;
  logic [NOW_W-1:0]       last_eff;
  logic [NOW_W-1:0]       dt_full;
  logic [STEP_W-1:0]      dt_cap;
  logic                   rise;
  logic [MS_W-1:0]        diff;
  logic [GAIN_W-1:0]      k_sel;
  logic signed [NT_W-1:0] nt_ceil;
  logic signed [NT_W-1:0] nt_clamped;

  assign n_eff   = (cnt_r < CNT_W'(regs.count_cap)) ? cnt_r[CAP_W-1:0] : regs.count_cap;
  assign abs_off = off_r[MS_W-1] ? (~off_r + MS_W'(1)) : off_r;

  always_comb begin
    mul_a = abs_off;
    mul_b = GAIN_W'(n_eff);
    case (cmd.op)
      OP_GAIN: begin
        mul_a = diff_r;
        mul_b = k_r;
      end
      OP_STEPH: begin
        mul_a = prod[PROD_W-1:GAIN_BITS];
        mul_b = GAIN_W'(dt_r);
      end
      OP_STEPL: begin
        mul_a = MS_W'(prod[GAIN_BITS-1:0]);
        mul_b = GAIN_W'(dt_r);
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // classification and adaptation setup, used in the class step; the few-deltas flag also in the scale and output steps
  always_comb begin
    status.few = (cnt_r < CNT_W'(2));

    mag     = prod[MAG_W-1:0];
    t_neg   = off_r[MS_W-1] && (mag != '0);
    above   = mag > MAG_W'(threshold);
    acc_sum = (ACC_W+1)'(over_accum) + (ACC_W+1)'(gap_r);
    if (!over_valid) begin
      acc_upd = ACC_W'(gap_r >> 1);
    end else if (acc_sum[ACC_W]) begin
      acc_upd = '1;
    end else begin
      acc_upd = acc_sum[ACC_W-1:0];
    end
    cnt_upd = (over_count == '1) ? over_count : over_count + CNT_W'(1);
    fire    = (acc_upd > ACC_W'(regs.over_limit)) && (cnt_upd > CNT_W'(1)) &&
              (off_r > prev_offset);

    last_eff = last_valid ? last_ms : now_r;
    dt_full  = (now_r >= last_eff) ? now_r - last_eff : '0;
    dt_cap   = (dt_full > NOW_W'(regs.max_step)) ? regs.max_step : dt_full[STEP_W-1:0];
    rise     = mag >= MAG_W'(threshold);
    // outside the skip case the difference fits the ms width
    diff     = rise ? MS_W'(mag - MAG_W'(threshold)) : MS_W'(MAG_W'(threshold) - mag);
    k_sel    = rise ? regs.gain_up : regs.gain_down;

    status.skip = mag > (MAG_W'(threshold) + MAG_W'(regs.margin));
  end

  // ceiling first, then floor, so the floor wins when they cross
  always_comb begin
    nt_ceil    = (nt_r > signed'(NT_W'(regs.ceiling_thr))) ?
                 signed'(NT_W'(regs.ceiling_thr)) : nt_r;
    nt_clamped = (nt_ceil < signed'(NT_W'(regs.floor_thr))) ?
                 signed'(NT_W'(regs.floor_thr)) : nt_ceil;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RST;
      over_accum  <= '0;
      over_valid  <= 1'b0;
      over_count  <= '0;
      prev_offset <= '0;
      last_ms     <= '0;
      last_valid  <= 1'b0;
      mode        <= USAGE_NORMAL;
    end else begin
      case (cmd.op)
        OP_CLASS: begin
          if (!t_neg && above) begin
            over_valid <= 1'b1;
            over_accum <= fire ? '0 : acc_upd;
            over_count <= fire ? '0 : cnt_upd;
            if (fire) begin
              mode <= USAGE_OVER;
            end
          end else begin
            over_valid <= 1'b0;
            over_accum <= '0;
            over_count <= '0;
            mode       <= t_neg && above ? USAGE_UNDER : USAGE_NORMAL;
          end
          prev_offset <= off_r;
          last_ms     <= now_r;
          last_valid  <= 1'b1;
        end
        OP_CLAMP: threshold <= nt_clamped[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        off_r <= delay_offset;
        gap_r <= group_gap;
        cnt_r <= delta_count;
        now_r <= now_ms;
      end
      OP_SCALE: prod <= mul_p;
      OP_CLASS: begin
        diff_r <= diff;
        k_r    <= k_sel;
        dt_r   <= dt_cap;
        rise_r <= rise;
      end
      OP_GAIN:  prod   <= mul_p;
      OP_STEPH: hi_r   <= mul_p[HI_W-1:0];
      OP_STEPL: lo_r   <= mul_p[GAIN_BITS+STEP_W-1:GAIN_BITS];
      OP_SUM:   step_r <= DELTA_W'(hi_r) + DELTA_W'(lo_r);
      OP_APPLY: begin
        nt_r <= rise_r ? signed'(NT_W'(threshold)) + signed'(NT_W'(step_r)) :
                         signed'(NT_W'(threshold)) - signed'(NT_W'(step_r));
      end
      OP_OUT: begin
        usage_state       <= status.few ? USAGE_NORMAL : mode;
        current_threshold <= threshold;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/delay_overuse_detector.sv */
// Delay overuse detector, top level. Ties together register file, sequencer
// and datapath; depends on dod_pkg, the interfaces in dod_ifs, dod_cfg,
// dod_ctrl and dod_dp.
//
// Usage:
//   cfg      register writes (index, data); always ready, one write per cycle.
//            Write only while no item is in flight.
//   estimate one delay-gradient item per handshake; ready only while the
//            sequencer is idle, so one item is worked on at a time.
//   result   one item (usage_state, current_threshold) per estimate, held in
//            an output register until taken.
// Steps: an item with fewer than two deltas goes from load straight to the
// final step, one with an offset beyond threshold plus margin stops after the
// class step, and a full adaptation also runs the gain, two time-step, sum,
// apply and clamp steps. The one shared 28x24 multiplier is used in turn for
// offset scaling, gain product and the two halves of the time-step product.
// The next item can be taken in the cycle after the previous result is loaded.
// Reset (rst, synchronous) restores the register defaults and the detector
// state. A stalled result holds the block in its final step until taken.
`default_nettype none

module delay_overuse_detector import dod_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  dod_cfg_if.sink   cfg,
  dod_est_if.sink   estimate,
  dod_res_if.source result
);

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  dod_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (regs)
  );

  dod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (estimate.valid),
    .in_ready  (estimate.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dod_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .regs              (regs),
    .delay_offset      (estimate.delay_offset),
    .group_gap         (estimate.group_gap),
    .delta_count       (estimate.delta_count),
    .now_ms            (estimate.now_ms),
    .usage_state       (result.usage_state),
    .current_threshold (result.current_threshold)
  );

endmodule

`default_nettype wire
